[src/byte_stuffed_frame_transmitter_defines.svh]
// ----------------------------------------------------------------------------
// Byte-stuffed frame transmitter assertion macros
// Assertion wrappers that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_FRAME_TRANSMITTER_DEFINES_SVH
`define BYTE_STUFFED_FRAME_TRANSMITTER_DEFINES_SVH

`ifndef SYNTH
`define BSFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bsft assertion failed");
`define BSFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bsft assertion failed");
`else
`define BSFT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BSFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/bsft_pkg.sv]
// ----------------------------------------------------------------------------
// Byte-stuffed frame transmitter package
// Line codes, CRC-16/X-25 step function and the run type shared by the stages.
// ----------------------------------------------------------------------------
package bsft_pkg;

	localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
	localparam logic [7:0]  ESC_BYTE   = 8'h7D;
	localparam logic [7:0]  ESC_XOR    = 8'h20;
	localparam logic [15:0] CRC_POLY_R = 16'h8408;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

	localparam int MAX_RUN   = 7;
	localparam int RUN_CNT_W = 3;

	// Line bytes caused by one input beat. closing marks the final entry as the
	// closing flag.
	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] bytes;
		logic [RUN_CNT_W-1:0]    count;
		logic                    closing;
	} run_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY_R;
			else      c = c >> 1;
		end
		return c;
	endfunction

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == FLAG_BYTE) || (b == ESC_BYTE);
	endfunction

endpackage

[src/bsft_framer.sv]
// ----------------------------------------------------------------------------
// Frame builder
// Input register, frame state and CRC, and the logic that expands one
// payload beat into its run of line bytes.
// ----------------------------------------------------------------------------
`include "byte_stuffed_frame_transmitter_defines.svh"

module bsft_framer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         payload_byte,
	input  logic               frame_last,
	output logic               run_valid,
	input  logic               run_take,
	output bsft_pkg::run_t     run
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        in_frame_q;
	logic [15:0] crc_q;
	logic [15:0] crc_next;
	logic [15:0] fcs;
	logic        advance;

	assign advance   = valid_s1 && run_take;
	assign in_stall  = valid_s1 && !run_take;
	assign run_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= payload_byte;
			last_s1 <= frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			crc_q      <= bsft_pkg::CRC_INIT;
		end else if (advance) begin
			if (last_s1) begin
				in_frame_q <= 1'b0;
				crc_q      <= bsft_pkg::CRC_INIT;
			end else begin
				in_frame_q <= 1'b1;
				crc_q      <= crc_next;
			end
		end
	end

	// The accumulator sits at its initial value whenever no frame is open.
	assign crc_next = bsft_pkg::crc_update(crc_q, byte_s1);
	assign fcs      = crc_next ^ bsft_pkg::CRC_XOROUT;

	always_comb begin
		logic [bsft_pkg::RUN_CNT_W-1:0] n;
		n = '0;
		run.bytes   = '0;
		run.closing = last_s1;
		if (!in_frame_q) begin
			run.bytes[n] = bsft_pkg::FLAG_BYTE;
			n = n + 3'd1;
		end
		if (bsft_pkg::needs_escape(byte_s1)) begin
			run.bytes[n]          = bsft_pkg::ESC_BYTE;
			run.bytes[3'(n + 3'd1)] = byte_s1 ^ bsft_pkg::ESC_XOR;
			n = n + 3'd2;
		end else begin
			run.bytes[n] = byte_s1;
			n = n + 3'd1;
		end
		if (last_s1) begin
			if (bsft_pkg::needs_escape(fcs[7:0])) begin
				run.bytes[n]          = bsft_pkg::ESC_BYTE;
				run.bytes[3'(n + 3'd1)] = fcs[7:0] ^ bsft_pkg::ESC_XOR;
				n = n + 3'd2;
			end else begin
				run.bytes[n] = fcs[7:0];
				n = n + 3'd1;
			end
			if (bsft_pkg::needs_escape(fcs[15:8])) begin
				run.bytes[n]          = bsft_pkg::ESC_BYTE;
				run.bytes[3'(n + 3'd1)] = fcs[15:8] ^ bsft_pkg::ESC_XOR;
				n = n + 3'd2;
			end else begin
				run.bytes[n] = fcs[15:8];
				n = n + 3'd1;
			end
			run.bytes[n] = bsft_pkg::FLAG_BYTE;
			n = n + 3'd1;
		end
		run.count = n;
	end

	`BSFT_ASSERT_IMPL(a_idle_crc_init, clk, arst_n, !in_frame_q, crc_q == bsft_pkg::CRC_INIT)
	`BSFT_ASSERT_IMPL(a_open_flag_first, clk, arst_n, run_valid && !in_frame_q,
		run.bytes[0] == bsft_pkg::FLAG_BYTE)

endmodule

[src/bsft_serializer.sv]
// ----------------------------------------------------------------------------
// Run serializer
// Holds one run of line bytes and sends one beat per cycle while not stalled.
// ----------------------------------------------------------------------------
`include "byte_stuffed_frame_transmitter_defines.svh"

module bsft_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 run_valid,
	output logic                 run_take,
	input  bsft_pkg::run_t       run,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           line_byte,
	output logic                 run_last,
	output logic                 frame_end
);

	bsft_pkg::run_t                 buf_q;
	logic [bsft_pkg::RUN_CNT_W-1:0] idx_q;
	logic                           busy_q;
	logic                           done;

	assign out_valid = busy_q;
	assign line_byte = buf_q.bytes[idx_q];
	assign run_last  = idx_q == 3'(buf_q.count - 3'd1);
	assign frame_end = run_last && buf_q.closing;

	// The next run loads in the same cycle the final beat of this one leaves.
	assign done     = busy_q && !out_stall && run_last;
	assign run_take = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (run_take && run_valid) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && !out_stall) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (run_take && run_valid) begin
			buf_q <= run;
		end
	end

	`BSFT_ASSERT_IMPL(a_idx_in_run, clk, arst_n, busy_q, idx_q < buf_q.count)
	`BSFT_ASSERT_IMPL(a_run_not_empty, clk, arst_n, run_valid, run.count != '0)
	`BSFT_ASSERT_NEXT(a_stall_holds_idx, clk, arst_n, busy_q && out_stall,
		busy_q && $stable(idx_q))

endmodule

[src/byte_stuffed_frame_transmitter.sv]
// ----------------------------------------------------------------------------
// Byte-stuffed frame transmitter
// HDLC-style framer with byte stuffing and a CRC-16/X-25 frame check.
// ----------------------------------------------------------------------------
// Each payload beat expands into a run of one to seven line bytes: an opening
// flag before the first byte of a frame, the byte itself (escaped as 0x7D,
// byte ^ 0x20 when it equals 0x7E or 0x7D), and after the last byte the
// escaped CRC low and high bytes and a closing flag. The line side emits one
// byte per cycle while out_stall is low; a run is one byte for an ordinary
// mid-frame byte, two for an escaped one, and up to seven for a frame's last
// byte. A beat is accepted every cycle while runs are one byte long and the
// line side is not stalled. Each beat passes through the framer's input
// register and the serializer's run buffer before its line bytes go out.
// run_last marks the final byte of each run and frame_end the closing flag.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_transmitter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] payload_byte,
	input  logic       frame_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] line_byte,
	output logic       run_last,
	output logic       frame_end
);

	bsft_pkg::run_t run;
	logic           run_valid;
	logic           run_take;

	bsft_framer u_framer (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.payload_byte (payload_byte),
		.frame_last   (frame_last),
		.run_valid    (run_valid),
		.run_take     (run_take),
		.run          (run)
	);

	bsft_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_valid (run_valid),
		.run_take  (run_take),
		.run       (run),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.line_byte (line_byte),
		.run_last  (run_last),
		.frame_end (frame_end)
	);

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame transmitter testbench
// Sends payload frames through the framer and checks every line byte against
// a predictor that builds the flags, escapes and CRC-16/X-25 check bytes.
// ----------------------------------------------------------------------------
module testbench;

	localparam int TOTAL_ITEMS    = 470;
	localparam int QUIET_ITEMS    = 60;
	localparam int CHOKE_AT       = 120;
	localparam int CHOKE_LEN      = 150;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 20;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       drain_first;
	} payload_beat_t;

	typedef struct packed {
		logic [7:0] octet;
		logic       run_last;
		logic       frame_end;
	} line_beat_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [7:0] payload_byte = 8'h00;
	logic       frame_last   = 1'b0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [7:0] line_byte;
	logic       run_last;
	logic       frame_end;

	payload_beat_t pending_beats[$];
	line_beat_t    expected_line[$];
	line_beat_t    run_buf[bsft_pkg::MAX_RUN];
	int            run_len;

	// Predictor state.
	logic        frame_open = 1'b0;
	logic [15:0] fcs_acc    = bsft_pkg::CRC_INIT;

	int beats_accepted  = 0;
	int lines_predicted = 0;
	int lines_checked   = 0;
	int frames_closed   = 0;
	int escapes_seen    = 0;
	int fails           = 0;
	int quiet_from      = TOTAL_ITEMS;
	int choke_left      = 0;
	bit choke_done      = 1'b0;
	int idle_cycles     = 0;

	byte_stuffed_frame_transmitter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.payload_byte(payload_byte),
		.frame_last  (frame_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.line_byte   (line_byte),
		.run_last    (run_last),
		.frame_end   (frame_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bit-serial CRC-16/X-25, LSB first.
	function automatic logic [15:0] fcs_shift_in(input logic [15:0] acc, input logic [7:0] data);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb  = acc[0] ^ data[i];
			acc = acc >> 1;
			if (fb) acc = acc ^ bsft_pkg::CRC_POLY_R;
		end
		return acc;
	endfunction

	function automatic logic is_ctrl_byte(input logic [7:0] b);
		return (b == bsft_pkg::FLAG_BYTE) || (b == bsft_pkg::ESC_BYTE);
	endfunction

	task automatic append_line(input logic [7:0] b, input logic closing);
		run_buf[run_len] = '{octet: b, run_last: 1'b0, frame_end: closing};
		run_len++;
	endtask

	task automatic append_escaped(input logic [7:0] b);
		if (is_ctrl_byte(b)) begin
			append_line(bsft_pkg::ESC_BYTE, 1'b0);
			append_line(b ^ bsft_pkg::ESC_XOR, 1'b0);
		end else begin
			append_line(b, 1'b0);
		end
	endtask

	// Builds the line bytes that one payload beat causes and queues them.
	task automatic predict_run(input logic [7:0] data, input logic last);
		logic [15:0] fcs;
		run_len = 0;
		if (!frame_open) begin
			append_line(bsft_pkg::FLAG_BYTE, 1'b0);
			frame_open = 1'b1;
			fcs_acc    = bsft_pkg::CRC_INIT;
		end
		fcs_acc = fcs_shift_in(fcs_acc, data);
		append_escaped(data);
		if (last) begin
			fcs = fcs_acc ^ bsft_pkg::CRC_XOROUT;
			append_escaped(fcs[7:0]);
			append_escaped(fcs[15:8]);
			append_line(bsft_pkg::FLAG_BYTE, 1'b1);
			frame_open = 1'b0;
			fcs_acc    = bsft_pkg::CRC_INIT;
		end
		run_buf[run_len-1].run_last = 1'b1;
		for (int i = 0; i < run_len; i++) expected_line.push_back(run_buf[i]);
		lines_predicted += run_len;
	endtask

	task automatic queue_beat(input logic [7:0] data, input logic last, input logic drain);
		pending_beats.push_back('{data: data, last: last, drain_first: drain});
	endtask

	task automatic queue_frame3(input logic [23:0] fr);
		queue_beat(fr[23:16], 1'b0, 1'b0);
		queue_beat(fr[15:8], 1'b0, 1'b0);
		queue_beat(fr[7:0], 1'b1, 1'b0);
	endtask

	always @(posedge clk) begin : drive_inputs
		int            send_gap;
		int            send_rate;
		int            send_phase;
		logic          nxt_valid;
		logic [7:0]    nxt_data;
		logic          nxt_last;
		payload_beat_t item;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			payload_byte <= 8'h00;
			frame_last   <= 1'b0;
			send_gap     = 0;
			send_rate    = 0;
			send_phase   = 0;
		end else begin
			nxt_valid = in_valid;
			nxt_data  = payload_byte;
			nxt_last  = frame_last;
			if (send_phase == 0) begin
				send_phase = $urandom_range(30, 150);
				case ($urandom_range(2))
					0: send_rate = 0;
					1: send_rate = 10;
					default: send_rate = 35;
				endcase
			end else begin
				send_phase--;
			end
			if (in_valid && !in_stall) begin
				predict_run(payload_byte, frame_last);
				beats_accepted <= beats_accepted + 1;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_beats.size() == 0) begin
					nxt_valid = 1'b0;
				end else if (pending_beats[0].drain_first && lines_predicted != lines_checked) begin
					// Hold off until every line byte predicted so far has come out.
					nxt_valid = 1'b0;
				end else if (send_rate != 0 && beats_accepted < quiet_from && choke_left == 0
						&& $urandom_range(99) < send_rate) begin
					send_gap = $urandom_range(0, 12);
				end else begin
					item      = pending_beats.pop_front();
					nxt_valid = 1'b1;
					nxt_data  = item.data;
					nxt_last  = item.last;
				end
			end
			in_valid     <= nxt_valid;
			payload_byte <= nxt_data;
			frame_last   <= nxt_last;
		end
	end

	always @(posedge clk) begin : check_outputs
		int         recv_gap;
		int         recv_rate;
		int         recv_phase;
		logic       nxt_stall;
		line_beat_t want;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			recv_gap   = 0;
			recv_rate  = 0;
			recv_phase = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_line.size() == 0) begin
					$display("%0t: unexpected line beat %02h (run_last %0b, frame_end %0b)",
						$time, line_byte, run_last, frame_end);
					fails++;
				end else begin
					want = expected_line.pop_front();
					lines_checked <= lines_checked + 1;
					if (line_byte !== want.octet) begin
						$display("%0t: line_byte expected %02h, got %02h",
							$time, want.octet, line_byte);
						fails++;
					end
					if (run_last !== want.run_last) begin
						$display("%0t: run_last expected %0b, got %0b",
							$time, want.run_last, run_last);
						fails++;
					end
					if (frame_end !== want.frame_end) begin
						$display("%0t: frame_end expected %0b, got %0b",
							$time, want.frame_end, frame_end);
						fails++;
					end
					if (want.frame_end) frames_closed++;
					if (want.octet == bsft_pkg::ESC_BYTE && !want.frame_end) escapes_seen++;
				end
			end
			if (recv_phase == 0) begin
				recv_phase = $urandom_range(30, 150);
				case ($urandom_range(2))
					0: recv_rate = 0;
					1: recv_rate = 10;
					default: recv_rate = 35;
				endcase
			end else begin
				recv_phase--;
			end
			// One long hold-off lets the framer fill up and push back on its input.
			if (choke_left > 0) begin
				nxt_stall = 1'b1;
				choke_left <= choke_left - 1;
			end else if (!choke_done && beats_accepted >= CHOKE_AT) begin
				nxt_stall = 1'b1;
				choke_done <= 1'b1;
				choke_left <= CHOKE_LEN - 1;
			end else if (recv_gap > 0) begin
				nxt_stall = 1'b1;
				recv_gap--;
			end else if (recv_rate != 0 && beats_accepted < quiet_from
					&& $urandom_range(99) < recv_rate) begin
				nxt_stall = 1'b1;
				recv_gap  = $urandom_range(0, 12);
			end else begin
				nxt_stall = 1'b0;
			end
			out_stall <= nxt_stall;
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [15:0] fcs;
		logic [7:0]  tail;
		logic [23:0] both_fr;
		logic [23:0] lo_fr;
		logic [23:0] hi_fr;
		bit          got_both;
		bit          got_lo;
		bit          got_hi;
		int          len;
		int          frame_no;
		logic [7:0]  b;
		got_both = 1'b0;
		got_lo   = 1'b0;
		got_hi   = 1'b0;

		// Single-byte frames at the field extremes and on both control codes.
		queue_beat(8'h00, 1'b1, 1'b0);
		queue_beat(8'hFF, 1'b1, 1'b0);
		queue_beat(bsft_pkg::FLAG_BYTE, 1'b1, 1'b0);
		queue_beat(bsft_pkg::ESC_BYTE, 1'b1, 1'b0);

		// Search for short frames whose check bytes need escaping: low byte only,
		// high byte only, and both behind an escaped last byte (the longest run).
		for (int x = 0; x < 256 && !(got_both && got_lo && got_hi); x++) begin
			for (int y = 0; y < 256; y++) begin
				for (int k = 0; k < 2; k++) begin
					tail = k ? bsft_pkg::FLAG_BYTE : bsft_pkg::ESC_BYTE;
					fcs  = fcs_shift_in(fcs_shift_in(fcs_shift_in(bsft_pkg::CRC_INIT,
						x[7:0]), y[7:0]), tail) ^ bsft_pkg::CRC_XOROUT;
					if (is_ctrl_byte(fcs[7:0]) && is_ctrl_byte(fcs[15:8]) && !got_both) begin
						got_both = 1'b1;
						both_fr  = {x[7:0], y[7:0], tail};
					end
					if (is_ctrl_byte(fcs[7:0]) && !is_ctrl_byte(fcs[15:8]) && !got_lo) begin
						got_lo = 1'b1;
						lo_fr  = {x[7:0], y[7:0], tail};
					end
					if (!is_ctrl_byte(fcs[7:0]) && is_ctrl_byte(fcs[15:8]) && !got_hi) begin
						got_hi = 1'b1;
						hi_fr  = {x[7:0], y[7:0], tail};
					end
				end
			end
		end
		queue_frame3(both_fr);
		queue_frame3(lo_fr);
		queue_frame3(hi_fr);

		// A longer frame mixing control codes with their escaped forms.
		queue_beat(bsft_pkg::FLAG_BYTE, 1'b0, 1'b0);
		queue_beat(bsft_pkg::ESC_BYTE, 1'b0, 1'b0);
		queue_beat(8'h5E, 1'b0, 1'b0);
		queue_beat(8'h5D, 1'b0, 1'b0);
		queue_beat(bsft_pkg::ESC_XOR, 1'b0, 1'b0);
		queue_beat(8'h80, 1'b0, 1'b0);
		queue_beat(8'h01, 1'b0, 1'b0);
		queue_beat(8'hFF, 1'b1, 1'b0);

		frame_no = 0;
		while (pending_beats.size() < TOTAL_ITEMS) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
			if (len > TOTAL_ITEMS - pending_beats.size())
				len = TOTAL_ITEMS - pending_beats.size();
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(7))
					0: b = bsft_pkg::FLAG_BYTE;
					1: b = bsft_pkg::ESC_BYTE;
					default: b = 8'($urandom);
				endcase
				// Drain pauses stay out of the final stretch, which runs without idling.
				queue_beat(b, i == len - 1, i == 0 && frame_no % 40 == 0
					&& pending_beats.size() < TOTAL_ITEMS - QUIET_ITEMS);
			end
			frame_no++;
		end
		quiet_from = pending_beats.size() - QUIET_ITEMS;

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (beats_accepted != TOTAL_ITEMS) @(posedge clk);
		while (lines_checked != lines_predicted) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d payload beats in %0d frames; checked %0d line bytes,",
			beats_accepted, frames_closed, lines_checked);
		$display("%0d of them escape pairs, with one long output hold-off.", escapes_seen);
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
